// File: sv/agpd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the ant grid decider.
`timescale 1ns / 1ps
`default_nettype none

package agpd_pkg;

    // Default grid side for the parameter of the top level
    localparam int GRID_MAX_DEF = 64;
    // Largest window half width honored; larger radius settings saturate here
    localparam int RADIUS_MAX   = 7;

    // Field widths fixed by the stream format
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 6;
    localparam int RND_W      = 7;
    localparam int CNT_W      = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int BS_W       = 7;
    localparam int VR_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BOARD_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_RADIUS = 1'd1;

    localparam logic [BS_W-1:0] BOARD_SIZE_RST  = 7'd64;
    localparam logic [VR_W-1:0] VIEW_RADIUS_RST = 3'd1;

    // Operation codes carried in tuser
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DROP  = 2'd2;

    // Scale of the random draw in the decision compare
    localparam logic [RND_W-1:0] RND_SCALE = 7'd100;

    // Commands from the controller, at most one per cycle
    typedef struct packed {
        logic load;
        logic clear_step;
        logic mod_step;
        logic back_step;
        logic scan_step;
        logic mul_sq;
        logic mul_scale;
        logic commit;
        logic push;
    } cmd_t;

    // Status from the datapath
    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic back_zero;
        logic scan_last;
        logic is_attempt;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: sv/agpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module agpd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/agpd_dpath.sv
// Datapath: configuration, coordinate wrap, window scan over the grid RAM, decision and result.
`timescale 1ns / 1ps
`default_nettype none

module agpd_dpath #(
    parameter int GRID_MAX = agpd_pkg::GRID_MAX_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  agpd_pkg::cmd_t                   cmd,
    output agpd_pkg::sts_t                   sts,
    input  wire                              cfg_we,
    input  wire [agpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [agpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire [agpd_pkg::IN_DATA_W-1:0]    in_data,
    input  wire [agpd_pkg::MODE_W-1:0]       in_mode,
    input  wire                              m_tready,
    output logic                             m_tvalid,
    output logic [agpd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int CW  = $clog2(GRID_MAX);
    localparam int NW  = $clog2(GRID_MAX + 1);
    localparam int AW  = 2 * CW;
    localparam int RW  = (agpd_pkg::COORD_W > CW) ? agpd_pkg::COORD_W : CW;
    localparam int SW  = NW + agpd_pkg::COORD_W;
    localparam int BW  = (NW > agpd_pkg::BS_W) ? NW : agpd_pkg::BS_W;
    localparam int KW  = $clog2(agpd_pkg::COORD_W);
    localparam int SDW = agpd_pkg::VR_W + 1;
    localparam int TW  = 2 * SDW;
    localparam int QW  = 2 * TW;
    localparam int PW  = QW + agpd_pkg::RND_W;

    // Configuration registers
    logic [agpd_pkg::BS_W-1:0] board_size_reg;
    logic [agpd_pkg::VR_W-1:0] view_radius_reg;

    // Item registers
    logic [agpd_pkg::MODE_W-1:0] mode_reg;
    logic                        cval_reg;
    logic [agpd_pkg::RND_W-1:0]  rnd_reg;
    logic [RW-1:0]               row_rem_reg, row_rem_next;
    logic [RW-1:0]               col_rem_reg, col_rem_next;
    logic [KW-1:0]               k_reg;

    // Window scan registers
    logic [CW-1:0]                 rr_reg, cc_reg, c0_reg;
    logic [agpd_pkg::VR_W-1:0]     back_cnt_reg;
    logic [SDW-1:0]                row_cnt_reg, col_cnt_reg;
    logic                          pend_reg;
    logic [agpd_pkg::CNT_W-1:0]    count_reg;
    logic [AW-1:0]                 clear_addr_reg;

    // Decision registers
    logic [TW-1:0] total_reg;
    logic [QW-1:0] tot2_reg, cnt2_reg;
    logic [PW-1:0] lhs_reg, rhs_reg;
    logic          res_act_reg;

    // Output register
    logic                       out_valid_reg;
    logic                       out_act_reg;
    logic [agpd_pkg::CNT_W-1:0] out_cnt_reg;

    logic [BW-1:0]             bs_ext;
    logic [NW-1:0]             n_eff, n_eff_m1;
    logic [CW-1:0]             n_m1;
    logic [agpd_pkg::VR_W-1:0] rad_eff;
    logic [SDW-1:0]            side, side_m1;
    logic [SW-1:0]             div_sh;
    logic                      want, is_attempt, hit, is_write;
    logic                      ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]             ram_waddr, ram_raddr;

    // Effective board size, saturated into [2, GRID_MAX]
    always_comb
    begin
        bs_ext = BW'(board_size_reg);
        if (bs_ext < BW'(2))
        begin
            n_eff = NW'(2);
        end
        else if (bs_ext > BW'(GRID_MAX))
        begin
            n_eff = NW'(GRID_MAX);
        end
        else
        begin
            n_eff = bs_ext[NW-1:0];
        end
    end

    assign n_eff_m1 = n_eff - 1'b1;
    assign n_m1     = n_eff_m1[CW-1:0];

    // Effective radius and window side
    assign rad_eff = ({1'b0, view_radius_reg} > SDW'(agpd_pkg::RADIUS_MAX))
                   ? agpd_pkg::VR_W'(agpd_pkg::RADIUS_MAX) : view_radius_reg;
    assign side    = {rad_eff, 1'b1};
    assign side_m1 = {rad_eff, 1'b0};

    assign is_write   = (mode_reg == agpd_pkg::MODE_WRITE);
    assign is_attempt = (mode_reg == agpd_pkg::MODE_PICK) || (mode_reg == agpd_pkg::MODE_DROP);
    assign want       = (mode_reg == agpd_pkg::MODE_DROP);
    assign hit        = (lhs_reg <= rhs_reg);

    // Toroidal step helpers
    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v, input logic [CW-1:0] top);
        wrap_inc = (v == top) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] v, input logic [CW-1:0] top);
        wrap_dec = (v == '0) ? top : v - 1'b1;
    endfunction

    // One restoring remainder step per cycle for row and column
    always_comb
    begin
        div_sh       = SW'(n_eff) << k_reg;
        row_rem_next = row_rem_reg;
        col_rem_next = col_rem_reg;
        if (SW'(row_rem_reg) >= div_sh)
        begin
            row_rem_next = RW'(SW'(row_rem_reg) - div_sh);
        end
        if (SW'(col_rem_reg) >= div_sh)
        begin
            col_rem_next = RW'(SW'(col_rem_reg) - div_sh);
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_size_reg  <= agpd_pkg::BOARD_SIZE_RST;
            view_radius_reg <= agpd_pkg::VIEW_RADIUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                agpd_pkg::REG_BOARD_SIZE:  board_size_reg  <= cfg_wdata[agpd_pkg::BS_W-1:0];
                agpd_pkg::REG_VIEW_RADIUS: view_radius_reg <= cfg_wdata[agpd_pkg::VR_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture and coordinate wrap
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= in_mode;
            row_rem_reg <= RW'(in_data[agpd_pkg::COORD_W-1:0]);
            col_rem_reg <= RW'(in_data[2*agpd_pkg::COORD_W-1:agpd_pkg::COORD_W]);
            cval_reg    <= in_data[2*agpd_pkg::COORD_W];
            rnd_reg     <= in_data[2*agpd_pkg::COORD_W+agpd_pkg::RND_W:2*agpd_pkg::COORD_W+1];
            k_reg       <= KW'(agpd_pkg::COORD_W - 1);
            total_reg   <= TW'(side * side);
        end
        else if (cmd.mod_step)
        begin
            row_rem_reg <= row_rem_next;
            col_rem_reg <= col_rem_next;
            k_reg       <= k_reg - 1'b1;
        end
    end

    // Window walk: back off by the radius, then raster over the square
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            back_cnt_reg <= rad_eff;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            rr_reg <= row_rem_next[CW-1:0];
            cc_reg <= col_rem_next[CW-1:0];
            c0_reg <= col_rem_next[CW-1:0];
        end
        else if (cmd.back_step)
        begin
            rr_reg       <= wrap_dec(rr_reg, n_m1);
            cc_reg       <= wrap_dec(cc_reg, n_m1);
            c0_reg       <= wrap_dec(cc_reg, n_m1);
            back_cnt_reg <= back_cnt_reg - 1'b1;
        end
        else if (cmd.scan_step)
        begin
            if (col_cnt_reg == side_m1)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_cnt_reg + 1'b1;
                cc_reg      <= c0_reg;
                rr_reg      <= wrap_inc(rr_reg, n_m1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
                cc_reg      <= wrap_inc(cc_reg, n_m1);
            end
        end
    end

    // Read pipeline and match counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            count_reg <= '0;
        end
        else if (pend_reg && (ram_rdata == want))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    // Decision arithmetic, one multiplier level per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul_sq)
        begin
            tot2_reg <= QW'(total_reg) * QW'(total_reg);
            cnt2_reg <= QW'(count_reg) * QW'(count_reg);
        end
        if (cmd.mul_scale)
        begin
            lhs_reg <= PW'(rnd_reg) * PW'(tot2_reg);
            rhs_reg <= PW'(agpd_pkg::RND_SCALE) * PW'(cnt2_reg);
        end
        if (cmd.commit)
        begin
            res_act_reg <= is_attempt && hit;
        end
    end

    // Grid RAM ports
    always_comb
    begin
        ram_raddr = {rr_reg, cc_reg};
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = cmd.commit && (is_write || (is_attempt && hit));
            ram_waddr = {row_rem_reg[CW-1:0], col_rem_reg[CW-1:0]};
            ram_wdata = is_write ? cval_reg : want;
        end
    end

    agpd_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register toward the master side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_act_reg <= res_act_reg;
            out_cnt_reg <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(agpd_pkg::OUT_DATA_W - agpd_pkg::CNT_W - 1)'(0), out_cnt_reg, out_act_reg};

    // Status
    assign sts.clear_last = &clear_addr_reg;
    assign sts.mod_last   = (k_reg == '0);
    assign sts.back_zero  = (back_cnt_reg == '0);
    assign sts.scan_last  = (col_cnt_reg == side_m1) && (row_cnt_reg == side_m1);
    assign sts.is_attempt = is_attempt;
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

// File: sv/agpd_ctrl.sv
// Controller: sequences clearing, coordinate wrap, window scan, decision and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module agpd_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            s_tvalid,
    output logic           s_tready,
    input  agpd_pkg::sts_t sts,
    output agpd_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_MOD    = 4'd2;
    localparam logic [3:0] ST_BACK   = 4'd3;
    localparam logic [3:0] ST_SCAN   = 4'd4;
    localparam logic [3:0] ST_DRAIN  = 4'd5;
    localparam logic [3:0] ST_MSQ    = 4'd6;
    localparam logic [3:0] ST_MSCALE = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;
    localparam logic [3:0] ST_PUSH   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = sts.is_attempt ? ST_BACK : ST_COMMIT;
                end
            end
            ST_BACK:
            begin
                if (sts.back_zero)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.back_step = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MSQ;
            end
            ST_MSQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = ST_MSCALE;
            end
            ST_MSCALE:
            begin
                cmd.mul_scale = 1'b1;
                state_next    = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/ant_grid_pick_drop_decider.sv
// Top level of the ant grid pick-up / drop-off decider: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a toroidal grid of one-bit cells in a single RAM and handles one transaction at a
// time. A write (or the unused mode) goes through the wrap of row and column, the commit
// and the result hand-off before its result is loaded into the output register. A
// pick-up or drop-off attempt wraps row and column, backs off by the radius to the window
// corner and reads the window one cell per cycle through the single RAM read port,
// followed by a drain state for the last read to land, the squaring and scaling
// multiplies, the commit with write-back and the result hand-off, which waits for a free
// output register. The next transaction can be accepted in the cycle after the result is
// loaded. After reset the grid is cleared one cell per cycle before the first transaction
// is accepted; configuration writes are taken at any time. The result register lets the
// next transaction be accepted while a result still waits on the master side.
module ant_grid_pick_drop_decider #(
    parameter int GRID_MAX = agpd_pkg::GRID_MAX_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // slave side
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // row[5:0], col[11:6], cell_value[12], random_value[19:13], zero[23:20]
    input  wire [agpd_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode[1:0]
    input  wire [agpd_pkg::MODE_W-1:0]       s_tuser,
    // master side
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // action_taken[0], match_count[8:1], zero[15:9]
    output logic [agpd_pkg::OUT_DATA_W-1:0]  m_tdata,
    // configuration
    input  wire                              cfg_we,
    input  wire [agpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [agpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    agpd_pkg::cmd_t cmd;
    agpd_pkg::sts_t sts;

    agpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    agpd_dpath #(
        .GRID_MAX (GRID_MAX)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_mode   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    // One transaction in flight: no acceptance in the cycle after one
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous transaction still in progress");

    // A result is only pushed into a free output register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.out_free)
        else $error("result pushed over an undelivered result");

    // Controller never issues two datapath commands at once
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

    // A pushed result becomes visible on the next cycle
    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> m_tvalid)
        else $error("pushed result not presented");

endmodule

`default_nettype wire

// File: tb/ant_grid_pick_drop_decider_tb.sv
// Self-checking testbench for the ant grid pick-up / drop-off decider.
`timescale 1ns / 1ps

module ant_grid_pick_drop_decider_tb;

    import agpd_pkg::*;

    localparam int GRID        = GRID_MAX_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 1000;
    localparam int DRAIN_WAIT  = 300;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 102;
    localparam int DIR_ROWS    = 23;

    // mode 3 is not an operation; the block must leave the grid alone
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               cell_value;
        logic [RND_W-1:0]   random_value;
    } ant_req_t;

    typedef struct packed {
        logic               action_taken;
        logic [CNT_W-1:0]   match_count;
    } ant_res_t;

    typedef struct packed {
        logic               is_cfg;
        logic [BS_W-1:0]    board;
        logic [VR_W-1:0]    radius;
        ant_req_t           req;
        logic               typed;
        ant_res_t           want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [MODE_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Predictor state: grid contents and raw register values
    logic                   grid_occ [GRID][GRID];
    logic [BS_W-1:0]        board_q;
    logic [VR_W-1:0]        radius_q;

    ant_res_t               pending_results [$];
    int                     mismatch_cnt = 0;
    int                     cycle_cnt = 0;

    // Receiver control
    logic                   sink_gaps_on = 1'b1;
    logic                   pressure_req = 1'b0;
    logic                   pressure_done = 1'b0;
    int                     sink_wait = 0;
    logic                   src_gaps_on = 1'b1;

    // Directed stimulus; typed rows carry an expectation read straight off the behavior
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{1'b0, 7'd0,   3'd0, '{MODE_PICK,  6'd0,  6'd0,  1'b0, 7'd0},   1'b1, '{1'b1, 8'd9}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd0,  6'd0,  1'b0, 7'd0},   1'b1, '{1'b1, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd63, 6'd63, 1'b0, 7'd99},  1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_WRITE, 6'd63, 6'd63, 1'b1, 7'd0},   1'b1, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_WRITE, 6'd63, 6'd0,  1'b1, 7'd0},   1'b1, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd0,  6'd63, 1'b0, 7'd20},  1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_SPARE, 6'd63, 6'd63, 1'b1, 7'd127}, 1'b1, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_WRITE, 6'd63, 6'd63, 1'b0, 7'd127}, 1'b1, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_PICK,  6'd62, 6'd62, 1'b1, 7'd127}, 1'b0, '{1'b0, 8'd0}},
        '{1'b1, 7'd64,  3'd0, '{MODE_WRITE, 6'd0,  6'd0,  1'b0, 7'd0},   1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd0,  6'd0,  1'b0, 7'd99},  1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd0,  6'd0,  1'b0, 7'd100}, 1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd0,  6'd0,  1'b0, 7'd101}, 1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_PICK,  6'd0,  6'd0,  1'b0, 7'd127}, 1'b0, '{1'b0, 8'd0}},
        '{1'b1, 7'd0,   3'd7, '{MODE_WRITE, 6'd0,  6'd0,  1'b0, 7'd0},   1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_PICK,  6'd63, 6'd63, 1'b0, 7'd50},  1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd1,  6'd0,  1'b0, 7'd0},   1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_WRITE, 6'd2,  6'd3,  1'b1, 7'd0},   1'b1, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd0,  6'd0,  1'b1, 7'd30},  1'b0, '{1'b0, 8'd0}},
        '{1'b1, 7'd127, 3'd2, '{MODE_WRITE, 6'd0,  6'd0,  1'b0, 7'd0},   1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_WRITE, 6'd40, 6'd21, 1'b1, 7'd85},  1'b1, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_PICK,  6'd40, 6'd21, 1'b0, 7'd10},  1'b0, '{1'b0, 8'd0}},
        '{1'b0, 7'd0,   3'd0, '{MODE_DROP,  6'd41, 6'd22, 1'b1, 7'd64},  1'b0, '{1'b0, 8'd0}}
    };

    ant_grid_pick_drop_decider dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
        begin
            return 0;
        end
        if (p < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Board side in use, saturated into [2, GRID]
    function automatic int board_in_use(input logic [BS_W-1:0] bs);
        if (bs < 2)
        begin
            return 2;
        end
        if (bs > GRID)
        begin
            return GRID;
        end
        return int'(bs);
    endfunction

    // Window count and decision for one transaction; updates the predicted grid
    function automatic ant_res_t resolve_ant_step(input ant_req_t q);
        ant_res_t    res;
        int          n;
        int          rad;
        int          r;
        int          c;
        int          rr;
        int          cc;
        int unsigned side;
        int unsigned total;
        int unsigned cnt;
        logic        want;
        res = '0;
        n = board_in_use(board_q);
        r = int'(q.row) % n;
        c = int'(q.col) % n;
        if (q.mode == MODE_WRITE)
        begin
            grid_occ[r][c] = q.cell_value;
        end
        else if (q.mode == MODE_PICK || q.mode == MODE_DROP)
        begin
            rad = (int'(radius_q) > RADIUS_MAX) ? RADIUS_MAX : int'(radius_q);
            want = (q.mode == MODE_DROP);
            side = 2 * rad + 1;
            total = side * side;
            cnt = 0;
            for (int di = -rad; di <= rad; di++)
            begin
                for (int dj = -rad; dj <= rad; dj++)
                begin
                    rr = ((r + di) % n + n) % n;
                    cc = ((c + dj) % n + n) % n;
                    if (grid_occ[rr][cc] == want)
                    begin
                        cnt++;
                    end
                end
            end
            res.match_count = cnt[CNT_W-1:0];
            if (int'(q.random_value) * total * total <= int'(RND_SCALE) * cnt * cnt)
            begin
                res.action_taken = 1'b1;
                grid_occ[r][c] = want;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 100)
        begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Offer one transaction after an optional gap; predict at acceptance
    task automatic send_item(input ant_req_t q, input logic typed, input ant_res_t want);
        int       gap;
        ant_res_t res;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.mode;
        s_tdata  <= {4'b0, q.random_value, q.cell_value, q.col, q.row};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        res = resolve_ant_step(q);
        pending_results.push_back(typed ? want : res);
    endtask

    // Wait for the block to drain, then write both registers
    task automatic write_config(input logic [BS_W-1:0] bs, input logic [CFG_DATA_W-1:0] vr);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= REG_BOARD_SIZE;
        cfg_wdata <= CFG_DATA_W'(bs);
        @(posedge clk);
        board_q   = bs;
        cfg_index <= REG_VIEW_RADIUS;
        cfg_wdata <= vr;
        @(posedge clk);
        radius_q  = vr[VR_W-1:0];
        cfg_we    <= 1'b0;
    endtask

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (pressure_req && !pressure_done)
        begin
            pressure_done <= 1'b1;
            sink_wait     <= HOLD_CYCLES;
            m_tready      <= 1'b0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (sink_gaps_on && $urandom_range(0, 3) == 0)
            begin
                sink_wait <= pick_gap();
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : check_results
        ant_res_t got;
        ant_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.action_taken = m_tdata[0];
            got.match_count  = m_tdata[CNT_W:1];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result transaction", int'(got), -1);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.action_taken !== exp_r.action_taken)
                begin
                    report_mismatch("action_taken", got.action_taken, exp_r.action_taken);
                end
                if (got.match_count !== exp_r.match_count)
                begin
                    report_mismatch("match_count", got.match_count, exp_r.match_count);
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        ant_req_t             q;
        int                   n;
        int                   span;
        int                   base_r;
        int                   base_c;
        int                   sel;
        logic [BS_W-1:0]      bs;
        logic [VR_W-1:0]      rad;
        logic [CFG_DATA_W-1:0] vr;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        board_q   = BOARD_SIZE_RST;
        radius_q  = VIEW_RADIUS_RST;
        for (int i = 0; i < GRID; i++)
        begin
            for (int j = 0; j < GRID; j++)
            begin
                grid_occ[i][j] = 1'b0;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        for (int k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_tab[k].is_cfg)
            begin
                write_config(dir_tab[k].board, CFG_DATA_W'(dir_tab[k].radius));
            end
            else
            begin
                send_item(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);
            end
        end

        // Random phases, each under its own configuration
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin bs = 7'd2;   rad = 3'd7; end
                1: begin bs = 7'd64;  rad = 3'd0; end
                2: begin bs = 7'd127; rad = 3'd7; end
                3: begin bs = 7'd1;   rad = 3'd3; end
                4: begin bs = 7'd8;   rad = 3'd1; end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        bs = BS_W'($urandom_range(0, 127));
                    end
                    else
                    begin
                        bs = BS_W'($urandom_range(2, 12));
                    end
                    rad = VR_W'($urandom_range(0, 7));
                end
            endcase
            // upper bits of the radius write are don't-care
            vr = {4'($urandom_range(0, 15)), rad};
            write_config(bs, vr);

            // idle-free stretches every fourth phase; the hold-off phase keeps offering
            src_gaps_on   = (phase % 4 != 3) && (phase != 4);
            sink_gaps_on <= (phase % 4 != 3);
            if (phase == 4)
            begin
                pressure_req <= 1'b1;
            end

            n = board_in_use(bs);
            span = (n < 6) ? n : 6;
            base_r = $urandom_range(0, n - 1);
            base_c = $urandom_range(0, n - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                begin
                    q.mode = MODE_SPARE;
                end
                else if (sel <= 6)
                begin
                    q.mode = MODE_WRITE;
                end
                else if (sel <= 13)
                begin
                    q.mode = MODE_PICK;
                end
                else
                begin
                    q.mode = MODE_DROP;
                end
                // cluster around a spot so windows overlap; sometimes any coordinate
                if ($urandom_range(0, 7) == 0)
                begin
                    q.row = COORD_W'($urandom_range(0, 63));
                    q.col = COORD_W'($urandom_range(0, 63));
                end
                else
                begin
                    q.row = COORD_W'((base_r + $urandom_range(0, span - 1)) % n);
                    q.col = COORD_W'((base_c + $urandom_range(0, span - 1)) % n);
                end
                q.cell_value = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0)
                begin
                    q.random_value = RND_W'($urandom_range(100, 127));
                end
                else
                begin
                    q.random_value = RND_W'($urandom_range(0, 99));
                end
                send_item(q, 1'b0, '0);
            end
        end

        // Drain and verdict
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_cnt == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
